### hdl/lfk_pkg.sv
// ----------------------------------------------------------------------------
// lfk_pkg
// shared types, constants and helpers for the leg forward kinematics block
// ----------------------------------------------------------------------------
package lfk_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int LENGTH_FRAC_BITS = 12;   // length unit, no effect on the integer math
    localparam int ANGLE_W          = 16;
    localparam int LEN_W            = 14;
    localparam int OUT_W            = 18;
    localparam int PHASE_W          = 32;
    localparam int CFG_IDX_W        = 3;

    // sine of a quarter-turn fraction, odd taylor terms in q30
    localparam logic [30:0] POLY_C11 = 31'd3864;
    localparam int          HORNER_N = 5;
    localparam logic [30:0] POLY_C [HORNER_N] = '{
        31'd172272, 31'd5026993, 31'd85569306, 31'd693598668, 31'd1686629713
    };
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;

    localparam logic signed [63:0] OUT_MAX = 64'sd131071;
    localparam logic signed [63:0] OUT_MIN = -64'sd131072;

    // pipeline depths of the back end
    localparam int SIN_LAT  = 8;
    localparam int BACK_LAT = SIN_LAT + 4;
    localparam int OFIFO_DEPTH = 16;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BODY_LENGTH  = 3'd0,
        REG_BODY_WIDTH   = 3'd1,
        REG_HIP_DROP     = 3'd2,
        REG_THIGH_LENGTH = 3'd3,
        REG_CALF_LENGTH  = 3'd4,
        REG_FOOT_LENGTH  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic [LEN_W-1:0] frame_width;
        logic [LEN_W-1:0] hip_drop;
        logic [LEN_W-1:0] thigh_length;
        logic [LEN_W-1:0] calf_length;
        logic [LEN_W-1:0] foot_length;
    } t_cfg;

    // one classified leg item, phases in 2^32 per turn
    typedef struct packed {
        logic [1:0]         leg;
        logic [PHASE_W-1:0] ph;
        logic [PHASE_W-1:0] pt;
        logic [PHASE_W-1:0] ptc;
    } t_issue_item;

    typedef struct packed {
        logic [1:0]              leg;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_result;

    // binary angle to 32-bit phase, wrapping mod one turn
    function automatic logic [PHASE_W-1:0] to_phase(input logic [ANGLE_W-1:0] a);
        logic signed [PHASE_W-1:0] ext;
        ext = PHASE_W'(signed'(a));
        return ext << (PHASE_W - ANGLE_BITS);
    endfunction

    // clamp to the output range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (c > OUT_MAX) c = OUT_MAX;
        if (c < OUT_MIN) c = OUT_MIN;
        return c[OUT_W-1:0];
    endfunction

endpackage

### hdl/lfk_front.sv
// ----------------------------------------------------------------------------
// lfk_front
// accepts leg items, forms the three phases and queues them for the back end
// ----------------------------------------------------------------------------
module lfk_front import lfk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_leg,
    input  logic [ANGLE_W-1:0]   i_hip,
    input  logic [ANGLE_W-1:0]   i_thigh,
    input  logic [ANGLE_W-1:0]   i_calf,
    output t_issue_item          o_item,
    output logic                 o_item_valid,
    input  logic                 i_pop
);

    t_issue_item            r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]      r_count;
    t_issue_item            w_new;
    logic                   w_push, w_pop;

    // phase forming, t+c wraps
    always_comb begin
        w_new.leg = i_leg;
        w_new.ph  = to_phase(i_hip);
        w_new.pt  = to_phase(i_thigh);
        w_new.ptc = to_phase(i_thigh) + to_phase(i_calf);
    end

    assign o_ready      = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_count != '0);
    assign w_pop        = i_pop && o_item_valid;
    assign o_item       = r_queue[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_new;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
        end
    end

endmodule

### hdl/lfk_sin.sv
// ----------------------------------------------------------------------------
// lfk_sin
// pipelined q30 sine of a 32-bit phase, at most one multiply per stage
// ----------------------------------------------------------------------------
module lfk_sin import lfk_pkg::*; (
    input  logic                i_clk,
    input  logic [PHASE_W-1:0]  i_phase,
    output logic signed [31:0]  o_value
);

    logic [30:0] r_x  [HORNER_N+2];
    logic [1:0]  r_q  [HORNER_N+2];
    logic [30:0] r_x2 [HORNER_N];
    logic [30:0] r_p  [HORNER_N+1];
    logic [61:0] w_sq;
    logic [61:0] w_fin;
    logic [30:0] w_s;

    // quadrant fold
    always_ff @(posedge i_clk) begin
        r_q[0] <= i_phase[31:30];
        r_x[0] <= i_phase[30] ? 31'(Q30_ONE) - {1'b0, i_phase[29:0]}
                              : {1'b0, i_phase[29:0]};
    end

    // square of the folded fraction
    assign w_sq = r_x[0] * r_x[0];
    always_ff @(posedge i_clk) begin
        r_q[1]  <= r_q[0];
        r_x[1]  <= r_x[0];
        r_x2[0] <= w_sq[60:30];
        r_p[0]  <= POLY_C11;
    end

    // horner steps
    for (genvar k = 0; k < HORNER_N; k++) begin : g_horner
        logic [61:0] w_prod;
        assign w_prod = r_x2[k] * r_p[k];
        always_ff @(posedge i_clk) begin
            r_q[k+2]  <= r_q[k+1];
            r_x[k+2]  <= r_x[k+1];
            r_p[k+1]  <= POLY_C[k] - w_prod[60:30];
        end
        // square carried only to the last horner step
        if (k < HORNER_N-1) begin : g_x2
            always_ff @(posedge i_clk) begin
                r_x2[k+1] <= r_x2[k];
            end
        end
    end

    // final multiply, clamp and sign
    assign w_fin = r_x[HORNER_N+1] * r_p[HORNER_N];
    assign w_s   = (w_fin[61:30] > 32'(Q30_ONE)) ? 31'(Q30_ONE) : w_fin[60:30];
    always_ff @(posedge i_clk) begin
        o_value <= r_q[HORNER_N+1][1] ? -signed'({1'b0, w_s}) : signed'({1'b0, w_s});
    end

endmodule

### hdl/lfk_back.sv
// ----------------------------------------------------------------------------
// lfk_back
// trig, products and rounding for one leg per cycle while the result fifo has room, plus a result fifo
// ----------------------------------------------------------------------------
module lfk_back import lfk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_issue_item i_item,
    input  logic        i_item_valid,
    output logic        o_pop,
    output t_result     o_result,
    output logic        o_valid,
    input  logic        i_ready
);

    logic                  r_vld [BACK_LAT];
    logic [1:0]            r_leg [BACK_LAT-1];
    logic [OFIFO_AW:0]     r_credit;
    logic                  w_out_pop;
    logic signed [31:0]    w_cos_pt, w_cos_ptc, w_sin_pt, w_sin_ptc, w_cos_ph, w_sin_ph;
    logic signed [15:0]    w_l2, w_lsum;

    // issue only with room reserved in the result fifo
    assign o_pop     = i_item_valid && (r_credit != (OFIFO_AW+1)'(OFIFO_DEPTH));
    assign w_out_pop = o_valid && i_ready;

    // trig units
    lfk_sin u_cos_pt  (.i_clk, .i_phase(i_item.pt + Q30_ONE),  .o_value(w_cos_pt));
    lfk_sin u_cos_ptc (.i_clk, .i_phase(i_item.ptc + Q30_ONE), .o_value(w_cos_ptc));
    lfk_sin u_sin_pt  (.i_clk, .i_phase(i_item.pt),            .o_value(w_sin_pt));
    lfk_sin u_sin_ptc (.i_clk, .i_phase(i_item.ptc),           .o_value(w_sin_ptc));
    lfk_sin u_cos_ph  (.i_clk, .i_phase(i_item.ph + Q30_ONE),  .o_value(w_cos_ph));
    lfk_sin u_sin_ph  (.i_clk, .i_phase(i_item.ph),            .o_value(w_sin_ph));

    // valid and leg tags along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BACK_LAT; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= o_pop;
            for (int i = 1; i < BACK_LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_leg[0] <= i_item.leg;
        for (int i = 1; i < BACK_LAT-1; i++) r_leg[i] <= r_leg[i-1];
    end

    // segment products
    assign w_l2   = signed'(16'(i_cfg.thigh_length));
    assign w_lsum = signed'(16'(i_cfg.calf_length) + 16'(i_cfg.foot_length));

    logic signed [47:0] r_pr_a, r_pr_b, r_pz_a, r_pz_b;
    logic signed [31:0] r_cph1, r_sph1, r_cph2, r_sph2;
    always_ff @(posedge i_clk) begin
        r_pr_a <= 48'(w_l2 * w_cos_pt);
        r_pr_b <= 48'(w_lsum * w_cos_ptc);
        r_pz_a <= 48'(w_l2 * w_sin_pt);
        r_pz_b <= 48'(w_lsum * w_sin_ptc);
        r_cph1 <= w_cos_ph;
        r_sph1 <= w_sin_ph;
    end

    // radius rounding to q16 and the finished z
    logic signed [47:0] w_r30;
    logic signed [63:0] w_z30;
    logic signed [33:0] r_r16;
    logic [OUT_W-1:0]   r_z [2];
    assign w_r30 = r_pr_a + r_pr_b + 48'sd8192;
    assign w_z30 = -(signed'(64'(i_cfg.hip_drop)) <<< 30) - 64'(r_pz_a) - 64'(r_pz_b)
                 + 64'sd536870912;
    always_ff @(posedge i_clk) begin
        r_r16  <= 34'(w_r30 >>> 14);
        r_z[0] <= sat_out(w_z30 >>> 30);
        r_cph2 <= r_cph1;
        r_sph2 <= r_sph1;
    end

    // radius times hip trig
    logic signed [63:0] r_px, r_py;
    always_ff @(posedge i_clk) begin
        r_px   <= 64'(r_r16 * r_cph2);
        r_py   <= 64'(r_r16 * r_sph2);
        r_z[1] <= r_z[0];
    end

    // add hip base, round and clamp
    logic signed [63:0] w_bx, w_by, w_x46, w_y46;
    logic [1:0]         w_leg_b;
    t_result            r_res;
    assign w_leg_b = r_leg[BACK_LAT-2];
    assign w_bx = w_leg_b[1] ? -(signed'(64'(i_cfg.frame_length)) <<< 45)
                             :  (signed'(64'(i_cfg.frame_length)) <<< 45);
    assign w_by = w_leg_b[0] ? -(signed'(64'(i_cfg.frame_width)) <<< 45)
                             :  (signed'(64'(i_cfg.frame_width)) <<< 45);
    assign w_x46 = w_bx + r_px + (64'sd1 <<< 45);
    assign w_y46 = w_by + r_py + (64'sd1 <<< 45);
    always_ff @(posedge i_clk) begin
        r_res.leg <= w_leg_b;
        r_res.x   <= sat_out(w_x46 >>> 46);
        r_res.y   <= sat_out(w_y46 >>> 46);
        r_res.z   <= r_z[1];
    end

    // result fifo
    t_result               r_fifo [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [OFIFO_AW:0]     r_count;
    logic                  w_push;
    assign w_push   = r_vld[BACK_LAT-1];
    assign o_valid  = (r_count != '0);
    assign o_result = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) r_fifo[r_wr_ptr] <= r_res;
    end

    // fifo pointers and credit count (items issued, not yet delivered)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_credit <= '0;
        end else begin
            if (w_push)    r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_out_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count  <= r_count + (OFIFO_AW+1)'(w_push) - (OFIFO_AW+1)'(w_out_pop);
            r_credit <= r_credit + (OFIFO_AW+1)'(o_pop) - (OFIFO_AW+1)'(w_out_pop);
        end
    end

endmodule

### hdl/leg_forward_kinematics.sv
// throughput: one leg per cycle while the result fifo has room, set by the fully pipelined sine and multiply path
// results wait in a 16-entry fifo; input stalls only when the queue is full, once issued items reserve the whole fifo
// reset: synchronous active low, clears queues and registers to zero lengths
// ----------------------------------------------------------------------------
// leg_forward_kinematics
// foot position of one leg from its hip, thigh and calf angles
// ----------------------------------------------------------------------------
module leg_forward_kinematics import lfk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,    // hip_angle, thigh_angle, calf_angle
    input  logic [1:0]           s_tuser,    // leg
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,    // foot_x, foot_y, foot_z, zero fill
    output logic [1:0]           m_tuser,    // leg_out
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    t_cfg        r_cfg;
    t_issue_item w_item;
    logic        w_item_valid, w_pop;
    t_result     w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BODY_LENGTH:  r_cfg.frame_length <= i_cfg_data;
                REG_BODY_WIDTH:   r_cfg.frame_width  <= i_cfg_data;
                REG_HIP_DROP:     r_cfg.hip_drop     <= i_cfg_data;
                REG_THIGH_LENGTH: r_cfg.thigh_length <= i_cfg_data;
                REG_CALF_LENGTH:  r_cfg.calf_length  <= i_cfg_data;
                REG_FOOT_LENGTH:  r_cfg.foot_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lfk_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_tvalid), .o_ready(s_tready),
        .i_leg(s_tuser),
        .i_hip(s_tdata[15:0]), .i_thigh(s_tdata[31:16]), .i_calf(s_tdata[47:32]),
        .o_item(w_item), .o_item_valid(w_item_valid), .i_pop(w_pop)
    );

    lfk_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_item(w_item), .i_item_valid(w_item_valid), .o_pop(w_pop),
        .o_result(w_res), .o_valid(m_tvalid), .i_ready(m_tready)
    );

    // output packing
    assign m_tdata = {2'b00, w_res.z, w_res.y, w_res.x};
    assign m_tuser = w_res.leg;

endmodule

### hdl/lfk_checker.sv
// ----------------------------------------------------------------------------
// lfk_checker
// port level checks for the leg forward kinematics block
// ----------------------------------------------------------------------------
module lfk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // pipe is empty after reset, so no result comes right after it
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid ##1 !m_tvalid) else $error("result right after reset");

    // queue is empty after reset, so input is taken
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_tready) else $error("input not ready after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind leg_forward_kinematics lfk_checker u_lfk_checker (
    .i_clk, .i_rst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);
